FILE: rtl/core/vlmd_pkg.sv
// ----------------------------------------------------------------------------
// vlmd_pkg: shared types for the varint length message deframer
// Result kinds, parser phases, result record and bus widths.
// ----------------------------------------------------------------------------
package vlmd_pkg;

   localparam int unsigned MAX_LENGTH_BYTES_DEF = 5;
   localparam int unsigned SEEN_W   = 3;   // length bytes seen counter
   localparam int unsigned LENGTH_W = 32;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned GROUP_W  = 7;   // payload bits per varint byte
   localparam int unsigned GROUPS_IN_LENGTH = 5;  // groups that reach into 32 bits
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 48;  // type, length, payload byte
   localparam int unsigned RSP_USER_W = 2;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN  = 2'd1,
      PH_PAY  = 2'd2
   } phase_type;

   typedef struct packed {
      logic                  valid;
      kind_type              kind;
      logic [BYTE_W-1:0]     msg_type;
      logic [LENGTH_W-1:0]   msg_length;
      logic [BYTE_W-1:0]     payload_byte;
      logic                  last;
   } result_type;

endpackage

FILE: rtl/core/varint_length_message_deframer.sv
// ----------------------------------------------------------------------------
// varint_length_message_deframer: type / varint length / payload deframer
// Datapath: an accepted byte is held in the input register, then its result
//   is held in the result register.
// Throughput: one byte per cycle while rsp_tready does not stall the output.
// Reset: synchronous, active high; returns to expecting a type byte and
//   empties both registers. No clearing pass.
// ----------------------------------------------------------------------------
module varint_length_message_deframer #(
   parameter int unsigned MAX_LENGTH_BYTES = vlmd_pkg::MAX_LENGTH_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // byte stream in
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [vlmd_pkg::REQ_DATA_W-1:0]      req_tdata,   // [7:0] data_byte
   // results out
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [vlmd_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [7:0] msg_type,
                                                             // [39:8] msg_length,
                                                             // [47:40] payload_byte
   output logic [vlmd_pkg::RSP_USER_W-1:0]      rsp_tuser,   // [1:0] out_kind
   output logic                                 rsp_tlast    // last_of_message
);
   import vlmd_pkg::*;

   logic               advance;     // held byte is consumed this cycle
   logic               byte_valid;
   logic [BYTE_W-1:0]  data_byte;
   result_type         result;      // parser result for the held byte

   // input register: decouples req_tready from the parser
   vlmd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .data_byte  (data_byte)
   );

   // framing state: type, varint length (truncated to 32 bits), payload count
   vlmd_parser #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (data_byte),
      .result    (result)
   );

   // result register: a new byte is parsed while the previous result transfers
   vlmd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .byte_valid (byte_valid),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/vlmd_in_stage.sv
// ----------------------------------------------------------------------------
// vlmd_in_stage: input byte register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module vlmd_in_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [vlmd_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 advance,
   output logic                                 byte_valid,
   output logic [vlmd_pkg::BYTE_W-1:0]          data_byte
);
   import vlmd_pkg::*;

   logic               valid_ff, valid_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               take;

   // free slot, or the held byte leaves this cycle
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_tdata[BYTE_W-1:0];
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign data_byte  = byte_ff;

endmodule

FILE: rtl/core/vlmd_parser.sv
// ----------------------------------------------------------------------------
// vlmd_parser: message framing state and result formation
// Type byte, varint length accumulation, payload countdown.
// ----------------------------------------------------------------------------
module vlmd_parser #(
   parameter int unsigned MAX_LENGTH_BYTES = vlmd_pkg::MAX_LENGTH_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [vlmd_pkg::BYTE_W-1:0]   data_byte,
   output vlmd_pkg::result_type          result
);
   import vlmd_pkg::*;

   localparam logic [SEEN_W-1:0] MAX_SEEN = SEEN_W'(MAX_LENGTH_BYTES);

   phase_type             phase_ff, phase_in;
   logic [BYTE_W-1:0]     type_ff, type_in;
   logic [LENGTH_W-1:0]   acc_ff, acc_in;
   logic [SEEN_W-1:0]     seen_ff, seen_in;
   logic [LENGTH_W-1:0]   rem_ff, rem_in;

   logic [5:0]            shamt;
   logic [LENGTH_W+GROUP_W-1:0] group_shifted;
   logic [LENGTH_W-1:0]   acc_or;
   logic [LENGTH_W-1:0]   rem_dec;

   // 7 * seen
   assign shamt = {seen_ff, 3'b000} - {3'b000, seen_ff};
   assign group_shifted = {{LENGTH_W{1'b0}}, data_byte[GROUP_W-1:0]} << shamt;
   assign acc_or = (seen_ff < SEEN_W'(GROUPS_IN_LENGTH))
                 ? (acc_ff | group_shifted[LENGTH_W-1:0]) : acc_ff;
   assign rem_dec = rem_ff - LENGTH_W'(1);

   // next state
   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      acc_in   = acc_ff;
      seen_in  = seen_ff;
      rem_in   = rem_ff;
      if (advance) begin
         case (phase_ff)
            PH_LEN: begin
               acc_in  = acc_or;
               seen_in = seen_ff + SEEN_W'(1);
               if (!data_byte[BYTE_W-1]) begin
                  if (acc_or == '0) begin
                     phase_in = PH_TYPE;
                  end else begin
                     rem_in   = acc_or;
                     phase_in = PH_PAY;
                  end
               end else if (seen_in >= MAX_SEEN) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_PAY: begin
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_TYPE;
               end
            end
            default: begin  // type byte, also the unused phase code
               type_in  = data_byte;
               acc_in   = '0;
               seen_in  = '0;
               rem_in   = '0;
               phase_in = PH_LEN;
            end
         endcase
      end
   end

   // result record
   always_comb begin
      result                = '0;
      result.kind           = KIND_HEADER;
      result.msg_type       = type_ff;
      case (phase_ff)
         PH_LEN: begin
            if (!data_byte[BYTE_W-1]) begin
               result.valid      = advance;
               result.kind       = KIND_HEADER;
               result.msg_length = acc_or;
               result.last       = (acc_or == '0);
            end else if ((seen_ff + SEEN_W'(1)) >= MAX_SEEN) begin
               result.valid = advance;
               result.kind  = KIND_ERROR;
            end
         end
         PH_PAY: begin
            result.valid        = advance;
            result.kind         = KIND_PAYLOAD;
            result.msg_length   = acc_ff;
            result.payload_byte = data_byte;
            result.last         = (rem_dec == '0);
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         type_ff  <= '0;
         acc_ff   <= '0;
         seen_ff  <= '0;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
         rem_ff   <= rem_in;
      end
   end

   a_pay_end: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_PAY && rem_ff == LENGTH_W'(1)) |=> phase_ff == PH_TYPE)
      else $error("payload countdown did not return to type phase");

   a_type_start: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff != PH_LEN && phase_ff != PH_PAY)
      |=> (phase_ff == PH_LEN && seen_ff == '0 && acc_ff == '0))
      else $error("type byte did not start a clean length field");

   a_err_src: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.kind == KIND_ERROR) |-> (phase_ff == PH_LEN && data_byte[7]))
      else $error("error result outside a continued length byte");

endmodule

FILE: rtl/core/vlmd_out_stage.sv
// ----------------------------------------------------------------------------
// vlmd_out_stage: result register
// Holds one result on the stream output until it is taken.
// ----------------------------------------------------------------------------
module vlmd_out_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vlmd_pkg::result_type                 result,
   input  logic                                 byte_valid,
   output logic                                 advance,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [vlmd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [vlmd_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);
   import vlmd_pkg::*;

   logic        valid_ff, valid_in;
   result_type  res_ff, res_in;
   logic        take;
   logic        load;

   assign take    = valid_ff && rsp_tready;
   // a byte moves on when the result slot is free or is emptied this cycle
   assign advance = byte_valid && (!valid_ff || rsp_tready);
   assign load    = result.valid;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = result;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.payload_byte, res_ff.msg_length, res_ff.msg_type};
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.last;

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      load |-> (!valid_ff || rsp_tready))
      else $error("result loaded over a pending transfer");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (take && !load) |=> !valid_ff)
      else $error("result register did not empty after transfer");

endmodule
